FILE: rtl/bitmap_frame_allocator_defines.svh
// Assertion macros used by the allocator controller.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int NUM_FRAMES_DEF  = 4096;
    localparam int FRAME_SHIFT_DEF = 12;

    localparam int ADDR_W  = 32;
    localparam int FADDR_W = 24;
    localparam int COUNT_W = 13;

    localparam logic [31:0]        FULL_WORD = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_ALLOC     = 2'd0,
        REQ_FREE      = 2'd1,
        REQ_MARK_USED = 2'd2,
        REQ_MARK_FREE = 2'd3
    } req_type_t;

    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic scan_start;
        logic scan_step;
        logic alloc_write;
        logic rmw_read;
        logic rmw_write;
        logic set_fail;
        logic load_out;
    } bfa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_alloc;
        logic in_range;
        logic found;
        logic exhausted;
    } bfa_sts_t;

    // Position of the lowest clear bit; only meaningful when one exists.
    function automatic logic [4:0] lowest_zero(input logic [31:0] word);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!word[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/bfa_if.sv
interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] address;

    modport source (output valid, output req_type, output address, input ready);
    modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface bfa_res_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [23:0] frame_address;
    logic [12:0] used_count;

    modport source (output valid, output ok, output frame_address, output used_count,
                    input ready);
    modport sink   (input valid, input ok, input frame_address, input used_count,
                    output ready);
endinterface

FILE: rtl/bitmap_frame_allocator.sv
// Channel  Dir  Payload                              Transfer
// req      in   req_type[1:0], address[31:0]         req.valid & req.ready
// res      out  ok, frame_address[23:0],             res.valid & res.ready
//               used_count[12:0]
//
// After reset all ceil(NUM_FRAMES/32) bitmap words (128 by default) are swept
// to all ones, one word a cycle, before the first request is taken.
// In-range free and mark requests go through dispatch, a read and a write of one
// bitmap word, and the result state. Alloc scans from word 0 up to the first word
// with a clear bit; a full bitmap fails after all NUM_FRAMES/32 words are read. The
// single memory read port, one bitmap word a cycle, sets the scan time.
// A stalled result waits in the output register; the next request is taken
// meanwhile and its result waits until that register is free.
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
    parameter int FRAME_SHIFT = FRAME_SHIFT_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    bfa_req_if.sink   req,
    bfa_res_if.source res
);

    bfa_cmd_t cmd;
    bfa_sts_t sts;

    bfa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfa_datapath #(
        .NUM_FRAMES  (NUM_FRAMES),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req.req_type),
        .address       (req.address),
        .cmd           (cmd),
        .sts           (sts),
        .ok            (res.ok),
        .frame_address (res.frame_address),
        .used_count    (res.used_count)
    );

endmodule

FILE: rtl/bfa_datapath.sv
module bfa_datapath
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
    parameter int FRAME_SHIFT = FRAME_SHIFT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         req_type,
    input  logic [ADDR_W-1:0]  address,
    input  bfa_cmd_t           cmd,
    output bfa_sts_t           sts,
    output logic               ok,
    output logic [FADDR_W-1:0] frame_address,
    output logic [COUNT_W-1:0] used_count
);

    localparam int WORD_COUNT = (NUM_FRAMES + 31) / 32;
    localparam int SCAN_WORDS = NUM_FRAMES / 32;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int FIDX_W     = WIDX_W + 5;
    localparam int SH_W       = FIDX_W + FRAME_SHIFT;
    localparam logic [WIDX_W-1:0] WORD_LAST = WIDX_W'(WORD_COUNT - 1);
    localparam logic [WIDX_W-1:0] SCAN_LAST = WIDX_W'(SCAN_WORDS - 1);

    logic [31:0]        mem [WORD_COUNT];
    logic [31:0]        rd_data_reg;

    req_type_t          req_type_reg;
    logic [FIDX_W-1:0]  frame_reg;
    logic               in_range_reg;

    logic [WIDX_W-1:0]  clr_idx_reg;
    logic [WIDX_W-1:0]  scan_idx_reg;
    logic [WIDX_W-1:0]  chk_idx_reg;
    logic               chk_valid_reg;
    logic               issue_done_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               pend_ok_reg;
    logic [FADDR_W-1:0] pend_faddr_reg;
    logic               ok_reg;
    logic [FADDR_W-1:0] faddr_reg;
    logic [COUNT_W-1:0] used_reg;

    logic [ADDR_W-1:0]          frame_full;
    logic                       found;
    logic                       exhausted;
    logic                       scan_issue;
    logic [4:0]                 zero_bit;
    logic [FIDX_W-1:0]          alloc_frame;
    logic [SH_W-1:0]            alloc_shift;
    logic [SH_W+FADDR_W-1:0]    alloc_wide;
    logic [FADDR_W-1:0]         alloc_faddr;
    logic [31:0]                bit_mask;
    logic [31:0]                rmw_word;
    logic                       rd_en;
    logic [WIDX_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [WIDX_W-1:0]          wr_addr;
    logic [31:0]                wr_data;

    assign frame_full = address >> FRAME_SHIFT;

    assign found      = chk_valid_reg && (rd_data_reg != FULL_WORD);
    assign exhausted  = issue_done_reg && !chk_valid_reg;
    // Stop issuing once a word with a hole is seen so its data stays put.
    assign scan_issue = cmd.scan_step && !issue_done_reg && !found;

    assign zero_bit    = lowest_zero(rd_data_reg);
    assign alloc_frame = {chk_idx_reg, zero_bit};
    assign alloc_shift = {alloc_frame, {FRAME_SHIFT{1'b0}}};
    assign alloc_wide  = {{FADDR_W{1'b0}}, alloc_shift};
    assign alloc_faddr = alloc_wide[FADDR_W-1:0];

    assign bit_mask = 32'(1) << frame_reg[4:0];
    assign rmw_word = (req_type_reg == REQ_MARK_USED) ? (rd_data_reg | bit_mask)
                                                      : (rd_data_reg & ~bit_mask);

    assign rd_en   = scan_issue || cmd.rmw_read;
    assign rd_addr = cmd.rmw_read ? frame_reg[FIDX_W-1:5] : scan_idx_reg;

    always_comb
    begin
        wr_en   = cmd.clear_step || cmd.alloc_write || cmd.rmw_write;
        wr_addr = clr_idx_reg;
        wr_data = FULL_WORD;
        if (cmd.alloc_write)
        begin
            wr_addr = chk_idx_reg;
            wr_data = rd_data_reg | (32'(1) << zero_bit);
        end
        else if (cmd.rmw_write)
        begin
            wr_addr = frame_reg[FIDX_W-1:5];
            wr_data = rmw_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.alloc_write && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.rmw_write && (req_type_reg == REQ_FREE) && (count_reg != '0))
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            scan_idx_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + WIDX_W'(1);
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                chk_valid_reg  <= 1'b0;
                issue_done_reg <= 1'b0;
            end
            else if (scan_issue)
            begin
                scan_idx_reg   <= scan_idx_reg + WIDX_W'(1);
                chk_valid_reg  <= 1'b1;
                issue_done_reg <= (scan_idx_reg == SCAN_LAST);
            end
            else if (cmd.scan_step)
            begin
                chk_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            chk_idx_reg <= scan_idx_reg;
        end
        if (cmd.load_req)
        begin
            req_type_reg <= req_type_t'(req_type);
            frame_reg    <= frame_full[FIDX_W-1:0];
            in_range_reg <= (frame_full < ADDR_W'(NUM_FRAMES));
        end
        if (cmd.alloc_write)
        begin
            pend_ok_reg    <= 1'b1;
            pend_faddr_reg <= alloc_faddr;
        end
        else if (cmd.rmw_write)
        begin
            pend_ok_reg    <= 1'b1;
            pend_faddr_reg <= '0;
        end
        else if (cmd.set_fail)
        begin
            pend_ok_reg    <= 1'b0;
            pend_faddr_reg <= '0;
        end
        if (cmd.load_out)
        begin
            ok_reg    <= pend_ok_reg;
            faddr_reg <= pend_faddr_reg;
            used_reg  <= count_reg;
        end
    end

    assign sts.clear_last = (clr_idx_reg == WORD_LAST);
    assign sts.is_alloc   = (req_type_reg == REQ_ALLOC);
    assign sts.in_range   = in_range_reg;
    assign sts.found      = found;
    assign sts.exhausted  = exhausted;

    assign ok            = ok_reg;
    assign frame_address = faddr_reg;
    assign used_count    = used_reg;

endmodule

FILE: rtl/bfa_controller.sv
`include "bitmap_frame_allocator_defines.svh"

module bfa_controller
    import bfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  bfa_sts_t sts,
    output bfa_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_DISPATCH = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_ALLOC    = 7'b0010000,
        ST_MODIFY   = 7'b0100000,
        ST_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.is_alloc)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else if (sts.in_range)
                begin
                    cmd.rmw_read = 1'b1;
                    state_next   = ST_MODIFY;
                end
                else
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.found)
                begin
                    state_next = ST_ALLOC;
                end
                else if (sts.exhausted)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc_write = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_MODIFY:
            begin
                cmd.rmw_write = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                // Hold the result until the output register frees up.
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BFA_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && in_ready, state_reg == ST_DISPATCH, "accepted request did not move to dispatch")
    `BFA_ASSERT_NEXT(a_clear_once, clk, rst_n, state_reg != ST_CLEAR, state_reg != ST_CLEAR, "bitmap clearing pass restarted")
    `BFA_ASSERT_IMP(a_alloc_after_found, clk, rst_n, cmd.alloc_write, $past(sts.found), "alloc write without a found word")
    `BFA_ASSERT_IMP(a_load_out_free, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready, "result overwrote an untaken transfer")

endmodule

FILE: verif/frame_alloc_checker.sv
module frame_alloc_checker
    import bfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bfa_req_if   req,
    bfa_res_if   res,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_WORDS  = (NUM_FRAMES_DEF + 31) / 32;
    localparam int SCAN_WORDS = NUM_FRAMES_DEF / 32;

    typedef struct packed {
        logic               ok;
        logic [FADDR_W-1:0] frame_address;
        logic [COUNT_W-1:0] used_count;
    } alloc_answer_t;

    logic [31:0]        frame_map [MAP_WORDS];
    logic [COUNT_W-1:0] used_frames;
    alloc_answer_t      expected_answers [$];
    alloc_answer_t      oldest;

    initial errors = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // Apply one request to the tracked bitmap and count, return the answer.
    function automatic alloc_answer_t allocator_answer(req_type_t kind, logic [31:0] addr);
        alloc_answer_t answer;
        logic [31:0]   frame;
        logic [63:0]   byte_addr;
        bit            found;
        answer = '0;
        frame  = addr >> FRAME_SHIFT_DEF;
        found  = 1'b0;
        if (kind == REQ_ALLOC)
        begin
            for (int w = 0; w < SCAN_WORDS; w++)
            begin
                if (!found && frame_map[w] != FULL_WORD)
                begin
                    for (int b = 0; b < 32; b++)
                    begin
                        if (!found && !frame_map[w][b])
                        begin
                            found = 1'b1;
                            frame = 32'(w * 32 + b);
                        end
                    end
                end
            end
            if (found)
            begin
                frame_map[frame[31:5]][frame[4:0]] = 1'b1;
                if (used_frames != COUNT_MAX)
                begin
                    used_frames++;
                end
                byte_addr            = 64'(frame) << FRAME_SHIFT_DEF;
                answer.frame_address = byte_addr[FADDR_W-1:0];
                answer.ok            = 1'b1;
            end
        end
        else if (frame < NUM_FRAMES_DEF)
        begin
            answer.ok = 1'b1;
            case (kind)
                REQ_FREE:
                begin
                    frame_map[frame[31:5]][frame[4:0]] = 1'b0;
                    // count saturates at zero, even on a double free
                    if (used_frames != '0)
                    begin
                        used_frames--;
                    end
                end
                REQ_MARK_USED:
                begin
                    frame_map[frame[31:5]][frame[4:0]] = 1'b1;
                end
                REQ_MARK_FREE:
                begin
                    frame_map[frame[31:5]][frame[4:0]] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        answer.used_count = used_frames;
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                frame_map[w] = FULL_WORD;
            end
            used_frames = '0;
            expected_answers.delete();
            pending <= 0;
        end
        else
        begin
            // check the result transfer first: it always belongs to an older request
            if (res.valid && res.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", res.ok, 0);
                end
                else
                begin
                    oldest = expected_answers.pop_front();
                    if (res.ok !== oldest.ok)
                    begin
                        report_mismatch("ok", res.ok, oldest.ok);
                    end
                    if (res.frame_address !== oldest.frame_address)
                    begin
                        report_mismatch("frame_address", res.frame_address,
                                        oldest.frame_address);
                    end
                    if (res.used_count !== oldest.used_count)
                    begin
                        report_mismatch("used_count", res.used_count, oldest.used_count);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_answers.push_back(
                    allocator_answer(req_type_t'(req.req_type), req.address));
            end
            pending <= expected_answers.size();
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench;
    import bfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int REUSE_PAIRS  = 12;
    localparam int DRAIN_GUARD  = 200;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   sent_count = 0;
    bit   idle_on    = 1'b1;
    bit   held_once  = 1'b0;

    bfa_req_if req_ch ();
    bfa_res_if res_ch ();

    bitmap_frame_allocator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    frame_alloc_checker checker_i
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Mostly low frames so allocs find them quickly; the rest anywhere in range.
    function automatic logic [31:0] random_frame_address();
        logic [31:0] frame;
        logic [31:0] offset;
        if ($urandom_range(0, 9) < 7)
        begin
            frame = $urandom_range(0, 255);
        end
        else
        begin
            frame = $urandom_range(0, NUM_FRAMES_DEF - 1);
        end
        offset = $urandom & ((32'd1 << FRAME_SHIFT_DEF) - 1);
        return (frame << FRAME_SHIFT_DEF) | offset;
    endfunction

    task automatic send_request(req_type_t kind, logic [31:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.address  <= addr;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    // Result side: random stalls, plus one long hold-off to fill the block.
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held_once && sent_count >= HOLD_AT)
            begin
                held_once = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int pick;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_ALLOC;
        req_ch.address  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // everything starts used: alloc must fail after a full scan
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        // free at zero count, then free the same frame again
        send_request(REQ_FREE, 32'h0000_0000);
        send_request(REQ_FREE, 32'h0000_0FFF);
        send_request(REQ_MARK_FREE, 32'h00FF_FFFF);
        // out of range on every non-alloc operation
        send_request(REQ_MARK_USED, 32'h0100_0000);
        send_request(REQ_FREE, 32'hFFFF_FFFF);
        send_request(REQ_MARK_FREE, 32'hFFFF_F000);
        send_request(REQ_ALLOC, 32'h0000_0000);
        // last frame of the last word
        send_request(REQ_ALLOC, 32'h5A5A_A5A5);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_MARK_FREE, 32'h0002_1000);
        send_request(REQ_MARK_FREE, 32'h0000_5000);
        send_request(REQ_ALLOC, 32'hA5A5_5A5A);
        send_request(REQ_MARK_USED, 32'h0002_1000);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_FREE, 32'h00FF_F000);
        send_request(REQ_FREE, 32'h00AA_A555);
        send_request(REQ_FREE, 32'h0055_5AAA);
        send_request(REQ_FREE, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_MARK_FREE, 32'h0000_1000);
        send_request(REQ_MARK_USED, 32'h00FF_FFFF);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_TAIL)
            begin
                idle_on = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_request(REQ_ALLOC, $urandom);
            end
            else if (pick < 65)
            begin
                send_request(REQ_FREE, random_frame_address());
            end
            else if (pick < 80)
            begin
                send_request(REQ_MARK_FREE, random_frame_address());
            end
            else if (pick < 90)
            begin
                send_request(REQ_MARK_USED, random_frame_address());
            end
            else
            begin
                // noise: any operation, mostly out-of-range addresses
                send_request(req_type_t'($urandom_range(0, 3)), $urandom);
            end
        end

        // recycle frame zero: each freed slot is allocated right away
        for (int i = 0; i < REUSE_PAIRS; i++)
        begin
            send_request(REQ_MARK_FREE, 32'h0000_0000);
            send_request(REQ_ALLOC, $urandom);
        end
        send_request(REQ_FREE, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'h0000_0000);

        drain_results();
        repeat (DRAIN_GUARD) @(posedge clk);
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_if.sv
rtl/bfa_datapath.sv
rtl/bfa_controller.sv
rtl/bitmap_frame_allocator.sv
verif/frame_alloc_checker.sv
verif/testbench.sv
